/* hw/rtl/pkfs_pkg.sv */
// shared types, constants and saturating helpers for the pseudo-kleinian fold step
package pkfs_pkg;

    localparam int VW = 48;
    localparam int DW = 47;
    localparam int HW = VW / 2;
    localparam int PW = 2 * VW;

    typedef logic signed [VW-1:0] val_t;
    typedef logic [VW-1:0]        umag_t;
    typedef logic [PW-1:0]        prod_t;

    localparam val_t VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam val_t VMIN = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [2:0] {
        CFG_FOLD_LIMIT,
        CFG_CENTER_OFFSET,
        CFG_MAX_SCALE,
        CFG_POST_ADD,
        CFG_PK_HEIGHT,
        CFG_PK_RADIUS,
        CFG_DIST_BIAS,
        CFG_MODE_BITS
    } cfg_idx_t;

    localparam int MODE_FLIP_Z   = 0;
    localparam int MODE_BOX_DE   = 1;
    localparam int MODE_SWAP_ABS = 2;
    localparam int MODE_USE_ABS  = 3;
    localparam int MODE_DE_EN    = 4;
    localparam int MODE_W        = 5;

    // four half-width partial products of a magnitude multiply
    typedef struct packed {
        logic [2*HW-1:0] ll;
        logic [2*HW-1:0] lh;
        logic [2*HW-1:0] hl;
        logic [2*HW-1:0] hh;
    } pp_t;

    function automatic val_t sat_wide(input logic [VW:0] v);
        if (v[VW] != v[VW-1])
        begin
            return v[VW] ? VMIN : VMAX;
        end
        return val_t'(v[VW-1:0]);
    endfunction

    function automatic val_t sat_add(input val_t a, input val_t b);
        logic [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        return sat_wide(s);
    endfunction

    function automatic val_t sat_sub(input val_t a, input val_t b);
        logic [VW:0] s;
        s = {a[VW-1], a} - {b[VW-1], b};
        return sat_wide(s);
    endfunction

    function automatic val_t sat_neg(input val_t a);
        return sat_sub(val_t'(0), a);
    endfunction

    function automatic val_t sat_abs(input val_t a);
        return a[VW-1] ? sat_neg(a) : a;
    endfunction

    function automatic umag_t mag(input val_t a);
        return a[VW-1] ? umag_t'(-a) : umag_t'(a);
    endfunction

    function automatic val_t smin(input val_t a, input val_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic val_t smax(input val_t a, input val_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pp_t mul_pp(input umag_t a, input umag_t b);
        pp_t p;
        p.ll = a[HW-1:0]    * b[HW-1:0];
        p.lh = a[HW-1:0]    * b[VW-1:HW];
        p.hl = a[VW-1:HW]   * b[HW-1:0];
        p.hh = a[VW-1:HW]   * b[VW-1:HW];
        return p;
    endfunction

    function automatic prod_t mul_sum(input pp_t p);
        return {p.hh, p.ll} + (prod_t'(p.lh) << HW) + (prod_t'(p.hl) << HW);
    endfunction

endpackage

/* hw/rtl/pkfs_div.sv */
// pipelined restoring divider, one quotient bit per stage, saturating signed result
module pkfs_div
    import pkfs_pkg::*;
#(
    parameter int F  = 32,
    parameter int SW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic          n_neg,
    input  umag_t         n_mag,
    input  umag_t         d_mag,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output val_t          quo,
    output logic [SW-1:0] side_out
);

    localparam int NB = VW + F;
    localparam int QW = VW - 1;

    logic          v_reg    [0:NB];
    logic          neg_reg  [0:NB];
    logic          dz_reg   [0:NB];
    logic          ovf_reg  [0:NB];
    logic [NB-1:0] n_reg    [0:NB];
    umag_t         d_reg    [0:NB];
    umag_t         rem_reg  [0:NB];
    logic [QW-1:0] q_reg    [0:NB];
    logic [SW-1:0] side_reg [0:NB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0]  <= n_neg;
            dz_reg[0]   <= (d_mag == '0);
            ovf_reg[0]  <= 1'b0;
            n_reg[0]    <= {n_mag, {F{1'b0}}};
            d_reg[0]    <= d_mag;
            rem_reg[0]  <= '0;
            q_reg[0]    <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar s = 1; s <= NB; s++)
    begin : g_bit
        logic [VW:0]   r2;
        logic          ge;
        umag_t         rem_next;
        logic [QW-1:0] q_next;
        logic          ovf_next;

        always_comb
        begin
            r2       = {rem_reg[s-1], n_reg[s-1][NB-1]};
            ge       = (r2 >= {1'b0, d_reg[s-1]});
            rem_next = ge ? umag_t'(r2 - {1'b0, d_reg[s-1]}) : r2[VW-1:0];
            q_next   = {q_reg[s-1][QW-2:0], ge};
            // quotient bits at weight 2^(VW-1) and above only flag saturation
            ovf_next = ovf_reg[s-1] | (ge && (s <= F + 1));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[s]  <= neg_reg[s-1];
                dz_reg[s]   <= dz_reg[s-1];
                ovf_reg[s]  <= ovf_next;
                n_reg[s]    <= {n_reg[s-1][NB-2:0], 1'b0};
                d_reg[s]    <= d_reg[s-1];
                rem_reg[s]  <= rem_next;
                q_reg[s]    <= q_next;
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_comb
    begin
        if (dz_reg[NB] || ovf_reg[NB])
        begin
            quo = neg_reg[NB] ? VMIN : VMAX;
        end
        else if (neg_reg[NB])
        begin
            quo = -val_t'({1'b0, q_reg[NB]});
        end
        else
        begin
            quo = val_t'({1'b0, q_reg[NB]});
        end
    end

    assign out_valid = v_reg[NB];
    assign side_out  = side_reg[NB];

endmodule

/* hw/rtl/pseudo_kleinian_fold_step.sv */
// pseudo-kleinian fold step: fold, inversion, scaling and distance estimate pipeline
//
//  channel | signals                                         | beat
//  --------+-------------------------------------------------+------------------------------
//  in      | in_valid/in_ready, pos_x..pos_w, deriv_in,      | one point per beat
//          | dist_in                                         |
//  out     | out_valid/out_ready, new_x..new_w, deriv_out,   | one result per input beat
//          | dist_out, step_dist                             |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data        | one register write per beat
//
// accepts one beat per cycle while no result waits untaken; the pipe runs through the
// three bit-serial dividers (VW+FRAC_BITS+1 stages each) and the 50-stage square root
// reset clears all valid bits and loads the register defaults; data stages are not reset
// one stall signal freezes every stage at once when the output beat is not taken,
// so a held result keeps its data and nothing upstream moves or is dropped
// cfg_ready is always high; the user must write registers only while the pipe is empty, the block does not enforce it
module pseudo_kleinian_fold_step
    import pkfs_pkg::*;
#(
    parameter int FRAC_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [VW-1:0] pos_x,
    input  logic signed [VW-1:0] pos_y,
    input  logic signed [VW-1:0] pos_z,
    input  logic signed [VW-1:0] pos_w,
    input  logic [DW-1:0]        deriv_in,
    input  logic signed [VW-1:0] dist_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [VW-1:0] new_x,
    output logic signed [VW-1:0] new_y,
    output logic signed [VW-1:0] new_z,
    output logic signed [VW-1:0] new_w,
    output logic [DW-1:0]        deriv_out,
    output logic signed [VW-1:0] dist_out,
    output logic signed [VW-1:0] step_dist,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [VW-1:0]        cfg_data
);

    localparam int   F   = FRAC_BITS;
    localparam int   RB  = VW + 1;      // root bits
    localparam int   OPW = 2 * RB;      // radicand bits
    localparam val_t ONE = val_t'(1) << F;

    // bundle behind the fold: post-added magnitudes, fold signs, derivative, distance
    typedef struct packed {
        val_t [3:0]    pa;
        logic [3:0]    pos;
        logic [3:0]    neg;
        logic [DW-1:0] d;
        val_t          run_dist;
    } sa_t;

    // bundle behind the scaling
    typedef struct packed {
        val_t [3:0]    z;
        logic [DW-1:0] de;
        val_t          run_dist;
    } sb_t;

    // bundle around the pseudo-kleinian quotient
    typedef struct packed {
        val_t a;
        val_t nbox;
        sb_t  sb;
    } sc_t;

    function automatic val_t qfix(input prod_t p, input logic neg);
        prod_t s;
        logic  big;
        s   = p >> F;
        big = (s >= (prod_t'(1) << (VW - 1)));
        if (big)
        begin
            return neg ? VMIN : VMAX;
        end
        return neg ? -val_t'(s[VW-1:0]) : val_t'(s[VW-1:0]);
    endfunction

    function automatic val_t root_clip(input logic [RB-1:0] r);
        return (r[RB-1] | r[VW-1]) ? VMAX : val_t'(r[VW-1:0]);
    endfunction

    // ---------------------------------------------------------------- config registers
    logic [DW-1:0]     fold_limit_reg;
    val_t              center_offset_reg;
    logic [DW-1:0]     max_scale_reg;
    val_t              post_add_reg;
    val_t              pk_height_reg;
    val_t              pk_radius_reg;
    val_t              dist_bias_reg;
    logic [MODE_W-1:0] mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_limit_reg    <= ONE[DW-1:0];
            center_offset_reg <= '0;
            max_scale_reg     <= ONE[DW-1:0];
            post_add_reg      <= '0;
            pk_height_reg     <= '0;
            pk_radius_reg     <= ONE;
            dist_bias_reg     <= '0;
            mode_reg          <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FOLD_LIMIT:    fold_limit_reg    <= cfg_data[DW-1:0];
                CFG_CENTER_OFFSET: center_offset_reg <= val_t'(cfg_data);
                CFG_MAX_SCALE:     max_scale_reg     <= cfg_data[DW-1:0];
                CFG_POST_ADD:      post_add_reg      <= val_t'(cfg_data);
                CFG_PK_HEIGHT:     pk_height_reg     <= val_t'(cfg_data);
                CFG_PK_RADIUS:     pk_radius_reg     <= val_t'(cfg_data);
                CFG_DIST_BIAS:     dist_bias_reg     <= val_t'(cfg_data);
                CFG_MODE_BITS:     mode_reg          <= cfg_data[MODE_W-1:0];
                default:           mode_reg          <= mode_reg;
            endcase
        end
    end

    val_t lim;
    val_t ms;
    logic raw;

    assign lim = val_t'({1'b0, fold_limit_reg});
    assign ms  = val_t'({1'b0, max_scale_reg});
    assign raw = mode_reg[MODE_SWAP_ABS] ^ mode_reg[MODE_USE_ABS];

    // ---------------------------------------------------------------- stall
    logic adv;
    logic o_v_reg;

    // whole pipe moves together; it only holds while a result waits
    assign adv      = !o_v_reg || out_ready;
    assign in_ready = adv;

    // ---------------------------------------------------------------- front: fold
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic s6_v_reg, s7_v_reg, s8_v_reg, s9_v_reg;

    val_t [3:0]    s1_x_reg;
    logic [DW-1:0] s1_d_reg;
    val_t          s1_dist_reg;

    val_t [3:0]    s2_a_reg;
    val_t [3:0]    s2_b_reg;
    val_t [3:0]    s2_x_reg;
    logic [DW-1:0] s2_d_reg;
    val_t          s2_dist_reg;

    val_t [3:0]    s3_f_reg;
    logic [DW-1:0] s3_d_reg;
    val_t          s3_dist_reg;

    val_t [3:0]    s4_m_reg;
    logic [3:0]    s4_pos_reg;
    logic [3:0]    s4_neg_reg;
    logic [DW-1:0] s4_d_reg;
    val_t          s4_dist_reg;

    val_t [3:0]    s5_tt_reg;
    sa_t           s5_sa_reg;
    pp_t [3:0]     s6_pp_reg;
    sa_t           s6_sa_reg;
    prod_t [3:0]   s7_sq_reg;
    sa_t           s7_sa_reg;
    logic [PW:0]   s8_s01_reg;
    logic [PW:0]   s8_s23_reg;
    sa_t           s8_sa_reg;
    logic [PW+1:0] s9_tot_reg;
    sa_t           s9_sa_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg    <= {pos_w, pos_z, pos_y, pos_x};
            s1_d_reg    <= deriv_in;
            s1_dist_reg <= dist_in;

            for (int i = 0; i < 4; i++)
            begin
                s2_a_reg[i] <= sat_abs(sat_add(s1_x_reg[i], lim));
                s2_b_reg[i] <= sat_abs(sat_sub(s1_x_reg[i], lim));
            end
            s2_x_reg    <= s1_x_reg;
            s2_d_reg    <= s1_d_reg;
            s2_dist_reg <= s1_dist_reg;

            for (int i = 0; i < 4; i++)
            begin
                s3_f_reg[i] <= sat_sub(sat_sub(s2_a_reg[i], s2_b_reg[i]), s2_x_reg[i]);
            end
            s3_d_reg    <= s2_d_reg;
            s3_dist_reg <= s2_dist_reg;

            for (int i = 0; i < 4; i++)
            begin
                s4_m_reg[i]   <= sat_abs(s3_f_reg[i]);
                s4_pos_reg[i] <= (s3_f_reg[i] > val_t'(0));
                s4_neg_reg[i] <= s3_f_reg[i][VW-1];
            end
            s4_d_reg    <= s3_d_reg;
            s4_dist_reg <= s3_dist_reg;

            for (int i = 0; i < 4; i++)
            begin
                s5_tt_reg[i]    <= sat_sub(s4_m_reg[i], center_offset_reg);
                s5_sa_reg.pa[i] <= sat_add(s4_m_reg[i], post_add_reg);
            end
            s5_sa_reg.pos      <= s4_pos_reg;
            s5_sa_reg.neg      <= s4_neg_reg;
            s5_sa_reg.d        <= s4_d_reg;
            s5_sa_reg.run_dist <= s4_dist_reg;

            // squared distance to the inversion center
            for (int i = 0; i < 4; i++)
            begin
                s6_pp_reg[i] <= mul_pp(mag(s5_tt_reg[i]), mag(s5_tt_reg[i]));
                s7_sq_reg[i] <= mul_sum(s6_pp_reg[i]);
            end
            s6_sa_reg <= s5_sa_reg;
            s7_sa_reg <= s6_sa_reg;

            s8_s01_reg <= {1'b0, s7_sq_reg[0]} + {1'b0, s7_sq_reg[1]};
            s8_s23_reg <= {1'b0, s7_sq_reg[2]} + {1'b0, s7_sq_reg[3]};
            s8_sa_reg  <= s7_sa_reg;

            s9_tot_reg <= {1'b0, s8_s01_reg} + {1'b0, s8_s23_reg};
            s9_sa_reg  <= s8_sa_reg;
        end
    end

    // ---------------------------------------------------------------- inversion scale
    logic [PW+1:0] trr_sh;
    umag_t         trr;

    assign trr_sh = s9_tot_reg >> F;
    assign trr    = (trr_sh > {{(PW+2-VW){1'b0}}, VMAX}) ? umag_t'(VMAX) : trr_sh[VW-1:0];

    logic                 da_valid;
    val_t                 da_quo;
    logic [$bits(sa_t)-1:0] da_side;

    pkfs_div #(
        .F  (F),
        .SW ($bits(sa_t))
    ) u_div_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s9_v_reg),
        .n_neg     (1'b0),
        .n_mag     (umag_t'(ONE)),
        .d_mag     (trr),
        .side_in   (s9_sa_reg),
        .out_valid (da_valid),
        .quo       (da_quo),
        .side_out  (da_side)
    );

    // ---------------------------------------------------------------- scaling
    logic t1_v_reg, t2_v_reg, t3_v_reg, t4_v_reg, t5_v_reg;

    val_t          t1_tp_reg;
    sa_t           t1_sa_reg;
    pp_t [3:0]     t2_pp_reg;
    pp_t           t2_ppd_reg;
    sa_t           t2_sa_reg;
    prod_t [3:0]   t3_pr_reg;
    prod_t         t3_prd_reg;
    sa_t           t3_sa_reg;
    val_t [3:0]    t4_s_reg;
    logic [DW-1:0] t4_de_reg;
    sa_t           t4_sa_reg;
    sb_t           t5_sb_reg;

    val_t       tp_lo;
    val_t       de_q;
    val_t [3:0] z_next;

    always_comb
    begin
        // clamp to one from below first, then to the register from above
        tp_lo = (da_quo < ONE) ? ONE : da_quo;
        de_q  = qfix(t3_prd_reg, 1'b0);
        for (int i = 0; i < 4; i++)
        begin
            if (t4_sa_reg.pos[i])
            begin
                z_next[i] = t4_s_reg[i];
            end
            else if (t4_sa_reg.neg[i])
            begin
                z_next[i] = sat_neg(t4_s_reg[i]);
            end
            else
            begin
                z_next[i] = '0;
            end
        end
        if (mode_reg[MODE_FLIP_Z])
        begin
            z_next[2] = sat_neg(z_next[2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_tp_reg <= (tp_lo > ms) ? ms : tp_lo;
            t1_sa_reg <= sa_t'(da_side);

            for (int i = 0; i < 4; i++)
            begin
                t2_pp_reg[i] <= mul_pp(mag(t1_sa_reg.pa[i]), umag_t'(t1_tp_reg));
                t3_pr_reg[i] <= mul_sum(t2_pp_reg[i]);
                t4_s_reg[i]  <= qfix(t3_pr_reg[i], t3_sa_reg.pa[i][VW-1]);
            end
            t2_ppd_reg <= mul_pp({1'b0, t1_sa_reg.d}, umag_t'(t1_tp_reg));
            t2_sa_reg  <= t1_sa_reg;
            t3_prd_reg <= mul_sum(t2_ppd_reg);
            t3_sa_reg  <= t2_sa_reg;
            t4_de_reg  <= de_q[DW-1:0];
            t4_sa_reg  <= t3_sa_reg;

            t5_sb_reg.z        <= z_next;
            t5_sb_reg.de       <= t4_de_reg;
            t5_sb_reg.run_dist <= t4_sa_reg.run_dist;
        end
    end

    // ---------------------------------------------------------------- radial sums
    logic q1_v_reg, q2_v_reg, q3_v_reg;

    pp_t [3:0]   q1_pp_reg;
    sb_t         q1_sb_reg;
    prod_t [3:0] q2_sq_reg;
    sb_t         q2_sb_reg;
    logic [PW:0] q3_sxy_reg;
    logic [PW:0] q3_s23_reg;
    sb_t         q3_sb_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                q1_pp_reg[i] <= mul_pp(mag(t5_sb_reg.z[i]), mag(t5_sb_reg.z[i]));
                q2_sq_reg[i] <= mul_sum(q1_pp_reg[i]);
            end
            q1_sb_reg  <= t5_sb_reg;
            q2_sb_reg  <= q1_sb_reg;
            q3_sxy_reg <= {1'b0, q2_sq_reg[0]} + {1'b0, q2_sq_reg[1]};
            q3_s23_reg <= {1'b0, q2_sq_reg[2]} + {1'b0, q2_sq_reg[3]};
            q3_sb_reg  <= q2_sb_reg;
        end
    end

    // ---------------------------------------------------------------- square roots
    // lane 0 is the xy radius, lane 1 the full point length; two radicand bits a stage
    logic                    sr_v_reg    [0:RB];
    logic [1:0][RB+1:0]      sr_rem_reg  [0:RB];
    logic [1:0][RB-1:0]      sr_root_reg [0:RB];
    logic [1:0][OPW-1:0]     sr_op_reg   [0:RB];
    sb_t                     sr_sb_reg   [0:RB];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sr_rem_reg[0]  <= '0;
            sr_root_reg[0] <= '0;
            sr_op_reg[0]   <= {OPW'({1'b0, q3_sxy_reg}) + OPW'(q3_s23_reg),
                               OPW'(q3_sxy_reg)};
            sr_sb_reg[0]   <= q3_sb_reg;
        end
    end

    for (genvar s = 1; s <= RB; s++)
    begin : g_root
        logic [1:0][RB-1:0]  root_next;
        logic [1:0][RB+1:0]  rem_next;

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [RB+3:0] r2;
            logic [RB+3:0] trial;
            logic          ge;

            always_comb
            begin
                r2           = {sr_rem_reg[s-1][l], sr_op_reg[s-1][l][OPW-1:OPW-2]};
                trial        = {2'b00, sr_root_reg[s-1][l], 2'b01};
                ge           = (r2 >= trial);
                rem_next[l]  = ge ? (RB+2)'(r2 - trial) : r2[RB+1:0];
                root_next[l] = {sr_root_reg[s-1][l][RB-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sr_rem_reg[s]  <= rem_next;
                sr_root_reg[s] <= root_next;
                sr_op_reg[s]   <= {sr_op_reg[s-1][1] << 2, sr_op_reg[s-1][0] << 2};
                sr_sb_reg[s]   <= sr_sb_reg[s-1];
            end
        end
    end

    // ---------------------------------------------------------------- distance terms
    logic p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg, p6_v_reg;

    val_t  p1_rxy_reg, p2_rxy_reg, p3_rxy_reg, p4_rxy_reg, p5_rxy_reg;
    val_t  p1_len_reg, p2_len_reg, p3_len_reg, p4_len_reg, p5_len_reg, p6_len_reg;
    sb_t   p1_sb_reg, p2_sb_reg, p3_sb_reg, p4_sb_reg, p5_sb_reg, p6_sb_reg;
    pp_t   p2_pp_reg;
    prod_t p3_pr_reg;
    val_t  p4_prod_reg;
    val_t  p5_t_reg;
    val_t  p5_a_reg;
    val_t  p5_hd_reg;
    val_t  p6_tsel_reg;
    val_t  p6_a_reg;
    val_t  p6_nbox_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_rxy_reg <= root_clip(sr_root_reg[RB][0]);
            p1_len_reg <= root_clip(sr_root_reg[RB][1]);
            p1_sb_reg  <= sr_sb_reg[RB];

            p2_pp_reg  <= mul_pp(umag_t'(p1_rxy_reg), mag(p1_sb_reg.z[2]));
            p2_rxy_reg <= p1_rxy_reg;
            p2_len_reg <= p1_len_reg;
            p2_sb_reg  <= p1_sb_reg;

            p3_pr_reg  <= mul_sum(p2_pp_reg);
            p3_rxy_reg <= p2_rxy_reg;
            p3_len_reg <= p2_len_reg;
            p3_sb_reg  <= p2_sb_reg;

            p4_prod_reg <= qfix(p3_pr_reg, p3_sb_reg.z[2][VW-1]);
            p4_rxy_reg  <= p3_rxy_reg;
            p4_len_reg  <= p3_len_reg;
            p4_sb_reg   <= p3_sb_reg;

            p5_t_reg   <= sat_sub(p4_prod_reg, pk_height_reg);
            p5_a_reg   <= sat_sub(p4_rxy_reg, pk_radius_reg);
            p5_hd_reg  <= sat_sub(p4_sb_reg.z[2], pk_height_reg);
            p5_rxy_reg <= p4_rxy_reg;
            p5_len_reg <= p4_len_reg;
            p5_sb_reg  <= p4_sb_reg;

            p6_tsel_reg <= raw ? p5_t_reg : sat_abs(p5_t_reg);
            p6_nbox_reg <= smin(p5_rxy_reg, sat_abs(p5_hd_reg));
            p6_a_reg    <= p5_a_reg;
            p6_len_reg  <= p5_len_reg;
            p6_sb_reg   <= p5_sb_reg;
        end
    end

    sc_t                    db_side_in;
    logic                   db_valid;
    val_t                   db_quo;
    logic [$bits(sc_t)-1:0] db_side;

    assign db_side_in = '{a: p6_a_reg, nbox: p6_nbox_reg, sb: p6_sb_reg};

    pkfs_div #(
        .F  (F),
        .SW ($bits(sc_t))
    ) u_div_kleinian (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p6_v_reg),
        .n_neg     (p6_tsel_reg[VW-1]),
        .n_mag     (mag(p6_tsel_reg)),
        .d_mag     (umag_t'(p6_len_reg)),
        .side_in   (db_side_in),
        .out_valid (db_valid),
        .quo       (db_quo),
        .side_out  (db_side)
    );

    // ---------------------------------------------------------------- estimate / derivative
    logic v1_v_reg;
    val_t v1_num_reg;
    sb_t  v1_sb_reg;
    sc_t  db_sc;

    assign db_sc = sc_t'(db_side);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v1_num_reg <= mode_reg[MODE_BOX_DE] ? db_sc.nbox : smax(db_sc.a, db_quo);
            v1_sb_reg  <= db_sc.sb;
        end
    end

    logic                   dc_valid;
    val_t                   dc_quo;
    logic [$bits(sb_t)-1:0] dc_side;

    pkfs_div #(
        .F  (F),
        .SW ($bits(sb_t))
    ) u_div_estimate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v1_v_reg),
        .n_neg     (v1_num_reg[VW-1]),
        .n_mag     (mag(v1_num_reg)),
        .d_mag     ({1'b0, v1_sb_reg.de}),
        .side_in   (v1_sb_reg),
        .out_valid (dc_valid),
        .quo       (dc_quo),
        .side_out  (dc_side)
    );

    // ---------------------------------------------------------------- result
    logic w1_v_reg;
    val_t w1_step_reg;
    sb_t  w1_sb_reg;

    val_t          o_x_reg, o_y_reg, o_z_reg, o_w_reg;
    logic [DW-1:0] o_de_reg;
    val_t          o_dist_reg;
    val_t          o_step_reg;
    logic          o_en_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_step_reg <= sat_sub(dc_quo, dist_bias_reg);
            w1_sb_reg   <= sb_t'(dc_side);

            o_x_reg  <= w1_sb_reg.z[0];
            o_y_reg  <= w1_sb_reg.z[1];
            o_z_reg  <= w1_sb_reg.z[2];
            o_w_reg  <= w1_sb_reg.z[3];
            o_de_reg <= w1_sb_reg.de;
            o_en_reg <= mode_reg[MODE_DE_EN];
            // with the estimate off the running distance passes through untouched
            if (mode_reg[MODE_DE_EN])
            begin
                o_dist_reg <= smin(w1_step_reg, w1_sb_reg.run_dist);
                o_step_reg <= w1_step_reg;
            end
            else
            begin
                o_dist_reg <= w1_sb_reg.run_dist;
                o_step_reg <= '0;
            end
        end
    end

    // ---------------------------------------------------------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
            s8_v_reg <= 1'b0;
            s9_v_reg <= 1'b0;
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
            t3_v_reg <= 1'b0;
            t4_v_reg <= 1'b0;
            t5_v_reg <= 1'b0;
            q1_v_reg <= 1'b0;
            q2_v_reg <= 1'b0;
            q3_v_reg <= 1'b0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
            p6_v_reg <= 1'b0;
            v1_v_reg <= 1'b0;
            w1_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
            for (int s = 0; s <= RB; s++)
            begin
                sr_v_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
            s7_v_reg <= s6_v_reg;
            s8_v_reg <= s7_v_reg;
            s9_v_reg <= s8_v_reg;
            t1_v_reg <= da_valid;
            t2_v_reg <= t1_v_reg;
            t3_v_reg <= t2_v_reg;
            t4_v_reg <= t3_v_reg;
            t5_v_reg <= t4_v_reg;
            q1_v_reg <= t5_v_reg;
            q2_v_reg <= q1_v_reg;
            q3_v_reg <= q2_v_reg;
            sr_v_reg[0] <= q3_v_reg;
            for (int s = 1; s <= RB; s++)
            begin
                sr_v_reg[s] <= sr_v_reg[s-1];
            end
            p1_v_reg <= sr_v_reg[RB];
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= p4_v_reg;
            p6_v_reg <= p5_v_reg;
            v1_v_reg <= db_valid;
            w1_v_reg <= dc_valid;
            o_v_reg  <= w1_v_reg;
        end
    end

    assign out_valid = o_v_reg;
    assign new_x     = o_x_reg;
    assign new_y     = o_y_reg;
    assign new_z     = o_z_reg;
    assign new_w     = o_w_reg;
    assign deriv_out = o_de_reg;
    assign dist_out  = o_dist_reg;
    assign step_dist = o_step_reg;

    // ---------------------------------------------------------------- checks
    // estimate off: this step reports no distance
    a_step_zero_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && !o_en_reg |-> o_step_reg == val_t'(0))
        else $error("step distance not zero with estimate disabled");

    // estimate on: running minimum never exceeds this step's estimate
    a_dist_is_min: assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && o_en_reg |-> o_dist_reg <= o_step_reg)
        else $error("running distance above step estimate");

    // a held result does not move while the pipe is frozen
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && !out_ready |=> o_v_reg && $stable(o_dist_reg) && $stable(o_de_reg))
        else $error("result changed while stalled");

endmodule
